// File: sv/rtli_pkg.sv
// rtli_pkg: shared types and constants of the ranked top-list insertion unit
// no dependencies; used by rtli_ctrl, rtli_datapath and the top level
package rtli_pkg;

   localparam int SCORE_W = 20;
   localparam int LIST_W  = 2;
   localparam int INDEX_W = 4;
   localparam int RANK_W  = 4;

   localparam logic [SCORE_W-1:0] EMPTY_MARK = SCORE_W'(1000000);
   localparam logic [SCORE_W-1:0] SCORE_MAX  = SCORE_W'(999999);

   localparam logic ACTION_INSERT = 1'b0;
   localparam logic ACTION_READ   = 1'b1;

   typedef struct packed {
      logic               action;
      logic [LIST_W-1:0]  list_select;
      logic [SCORE_W-1:0] new_score;
      logic [INDEX_W-1:0] entry_index;
   } req_type;

   typedef struct packed {
      logic [RANK_W-1:0]  rank;
      logic [SCORE_W-1:0] entry_score;
      logic               entry_empty;
   } rsp_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic walk;
      logic rd_issue;
      logic rd_capture;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic walk_last;
      logic in_insert_ok;
      logic in_read_ok;
   } status_type;

endpackage

// File: sv/rtli_ram.sv
// rtli_ram: generic one-write one-read memory with registered read data
// no dependencies
module rtli_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 30
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/rtli_ctrl.sv
// rtli_ctrl: sequencing state machine of the ranked top-list insertion unit
// depends on rtli_pkg for the command and status structs
module rtli_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                action,
   input  rtli_pkg::status_type status,
   output rtli_pkg::cmd_type    cmd,
   output logic                busy,
   output logic                rsp_strobe
);

   typedef enum logic [5:0] {
      CLEAR    = 6'b000001,
      IDLE     = 6'b000010,
      WALK     = 6'b000100,
      RD_ISSUE = 6'b001000,
      RD_DATA  = 6'b010000,
      RESPOND  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign accept = start && (state_ff == IDLE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CLEAR: begin
            if (status.clear_last) state_in = IDLE;
         end
         IDLE: begin
            if (start) begin
               if (action == rtli_pkg::ACTION_INSERT && status.in_insert_ok) begin
                  state_in = WALK;
               end else if (action == rtli_pkg::ACTION_READ && status.in_read_ok) begin
                  state_in = RD_ISSUE;
               end else begin
                  state_in = RESPOND;
               end
            end
         end
         WALK: begin
            if (status.walk_last) state_in = RESPOND;
         end
         RD_ISSUE: state_in = RD_DATA;
         RD_DATA:  state_in = RESPOND;
         RESPOND:  state_in = IDLE;
         default:  state_in = CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd            = '0;
      cmd.clear      = (state_ff == CLEAR);
      cmd.load       = accept;
      cmd.walk       = (state_ff == WALK);
      cmd.rd_issue   = (state_ff == RD_ISSUE);
      cmd.rd_capture = (state_ff == RD_DATA);
   end

   assign busy       = (state_ff != IDLE);
   assign rsp_strobe = (state_ff == RESPOND);

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != IDLE))
      else $error("accepted transaction did not leave idle");

   a_walk_ends_in_respond: assert property (@(posedge clock) disable iff (reset)
      (state_ff == WALK && status.walk_last) |=> rsp_strobe)
      else $error("finished walk did not respond");

   a_read_sequence: assert property (@(posedge clock) disable iff (reset)
      (state_ff == RD_ISSUE) |=> (state_ff == RD_DATA) ##1 rsp_strobe)
      else $error("read did not respond two cycles after issue");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> (!rsp_strobe && !busy))
      else $error("result strobe longer than one cycle");

endmodule

// File: sv/rtli_datapath.sv
// rtli_datapath: list memory, insertion walk and result register
// depends on rtli_pkg and rtli_ram
module rtli_datapath #(
   parameter int LIST_DEPTH = 10,
   parameter int NUM_LISTS  = 3
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rtli_pkg::cmd_type    cmd,
   input  rtli_pkg::req_type    req_item,
   output rtli_pkg::status_type status,
   output rtli_pkg::rsp_type    rsp_item
);

   localparam int TOTAL  = NUM_LISTS * LIST_DEPTH;
   localparam int ADDR_W = $clog2(TOTAL);
   localparam int POS_W  = $clog2(LIST_DEPTH);
   localparam int STEP_W = $clog2(LIST_DEPTH + 1);

   logic [ADDR_W-1:0]            clr_ff, clr_in;
   logic [STEP_W-1:0]            step_ff, step_in;
   logic                         proc_valid_ff, proc_valid_in;
   logic [POS_W-1:0]             proc_pos_ff, proc_pos_in;
   logic                         inserted_ff, inserted_in;
   logic [rtli_pkg::SCORE_W-1:0] score_ff, score_in;
   logic [rtli_pkg::SCORE_W-1:0] carry_ff, carry_in;
   logic [ADDR_W-1:0]            base_ff, base_in;
   logic [POS_W-1:0]             index_ff, index_in;
   rtli_pkg::rsp_type            res_ff, res_in;

   logic                         list_ok;
   logic                         step_active;
   logic                         hit;
   logic                         wr_en;
   logic [ADDR_W-1:0]            wr_addr;
   logic [rtli_pkg::SCORE_W-1:0] wr_data;
   logic                         rd_en;
   logic [ADDR_W-1:0]            rd_addr;
   logic [rtli_pkg::SCORE_W-1:0] rd_data;

   assign list_ok     = 32'(req_item.list_select) < NUM_LISTS;
   assign step_active = step_ff < STEP_W'(LIST_DEPTH);
   assign hit         = proc_valid_ff && !inserted_ff && (score_ff < rd_data);

   always_comb begin
      status              = '0;
      status.clear_last   = (clr_ff == ADDR_W'(TOTAL - 1));
      status.walk_last    = (step_ff == STEP_W'(LIST_DEPTH));
      status.in_insert_ok = list_ok;
      status.in_read_ok   = list_ok && (32'(req_item.entry_index) < LIST_DEPTH);
   end

   always_comb begin
      clr_in        = cmd.clear ? clr_ff + ADDR_W'(1) : clr_ff;
      step_in       = step_ff;
      proc_valid_in = cmd.walk && step_active;
      proc_pos_in   = POS_W'(step_ff);
      inserted_in   = inserted_ff;
      score_in      = score_ff;
      carry_in      = carry_ff;
      base_in       = base_ff;
      index_in      = index_ff;
      res_in        = res_ff;

      if (cmd.load) begin
         step_in     = '0;
         inserted_in = 1'b0;
         score_in    = (req_item.new_score > rtli_pkg::SCORE_MAX) ?
                       rtli_pkg::SCORE_MAX : req_item.new_score;
         carry_in    = rtli_pkg::EMPTY_MARK;
         base_in     = ADDR_W'(32'(req_item.list_select) * LIST_DEPTH);
         index_in    = POS_W'(req_item.entry_index);
         res_in      = '0;
         if (req_item.action == rtli_pkg::ACTION_READ) begin
            res_in.entry_score = rtli_pkg::EMPTY_MARK;
            res_in.entry_empty = 1'b1;
         end
      end

      if (cmd.walk && step_active) begin
         step_in = step_ff + STEP_W'(1);
      end

      if (proc_valid_ff) begin
         carry_in = rd_data;
         if (hit) begin
            inserted_in = 1'b1;
            res_in.rank = rtli_pkg::RANK_W'(proc_pos_ff) + rtli_pkg::RANK_W'(1);
         end
      end

      if (cmd.rd_capture) begin
         res_in.entry_score = rd_data;
         res_in.entry_empty = (rd_data == rtli_pkg::EMPTY_MARK);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff        <= '0;
         step_ff       <= '0;
         proc_valid_ff <= 1'b0;
         inserted_ff   <= 1'b0;
      end else begin
         clr_ff        <= clr_in;
         step_ff       <= step_in;
         proc_valid_ff <= proc_valid_in;
         inserted_ff   <= inserted_in;
      end
   end

   always_ff @(posedge clock) begin
      proc_pos_ff <= proc_pos_in;
      score_ff    <= score_in;
      carry_ff    <= carry_in;
      base_ff     <= base_in;
      index_ff    <= index_in;
      res_ff      <= res_in;
   end

   always_comb begin
      if (cmd.clear) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         wr_data = rtli_pkg::EMPTY_MARK;
      end else begin
         wr_en   = proc_valid_ff && (hit || inserted_ff);
         wr_addr = base_ff + ADDR_W'(proc_pos_ff);
         wr_data = hit ? score_ff : carry_ff;
      end
   end

   assign rd_en   = cmd.rd_issue || (cmd.walk && step_active);
   assign rd_addr = cmd.rd_issue ? base_ff + ADDR_W'(index_ff)
                                 : base_ff + ADDR_W'(POS_W'(step_ff));

   rtli_ram #(
      .WIDTH (rtli_pkg::SCORE_W),
      .DEPTH (TOTAL)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_item = res_ff;

   a_no_walk_during_clear: assert property (@(posedge clock) disable iff (reset)
      proc_valid_ff |-> !cmd.clear)
      else $error("insertion walk overlaps clearing pass");

   a_shift_writes: assert property (@(posedge clock) disable iff (reset)
      (proc_valid_ff && inserted_ff) |-> (wr_en && wr_data == carry_ff))
      else $error("entry after insertion point not shifted");

   a_single_insert: assert property (@(posedge clock) disable iff (reset)
      (proc_valid_ff && inserted_ff) |-> !hit)
      else $error("score inserted twice in one walk");

endmodule

// File: sv/ranked_top_list_insertion_unit.sv
// ranked_top_list_insertion_unit: top level, joins controller and datapath
// depends on rtli_pkg, rtli_ctrl, rtli_datapath
//
// Keeps NUM_LISTS ascending lists of LIST_DEPTH scores (lower is better) in one
// memory. A transaction is taken when start is high and busy is low; its single
// result appears on rsp_item for exactly one cycle with rsp_strobe high and must
// be taken then, since the unit cannot be held off. An insert walks the list
// once through the memory port, one entry per cycle, shifting later entries
// down as it goes. A read passes through RD_ISSUE and RD_DATA before RESPOND;
// a transaction naming an unknown list, or a read naming an unknown index,
// goes straight to RESPOND. After reset a clearing pass fills all
// NUM_LISTS * LIST_DEPTH entries with the empty marker while busy stays high.
module ranked_top_list_insertion_unit #(
   parameter int LIST_DEPTH = 10,
   parameter int NUM_LISTS  = 3
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  rtli_pkg::req_type req_item,
   output logic              rsp_strobe,
   output rtli_pkg::rsp_type rsp_item
);

   rtli_pkg::cmd_type    cmd;
   rtli_pkg::status_type status;

   rtli_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .action     (req_item.action),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   rtli_datapath #(
      .LIST_DEPTH (LIST_DEPTH),
      .NUM_LISTS  (NUM_LISTS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_item (req_item),
      .status   (status),
      .rsp_item (rsp_item)
   );

endmodule
